>>> rtl/core/bsx_pkg.sv
// shared types, constants and helpers for the bit-banged serial exchanger
package bsx_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 6;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int STEP_W      = 5;

  localparam logic [COUNT_W-1:0] STORE_LIMIT = COUNT_W'(STORE_DEPTH - 1);
  localparam logic [STEP_W-1:0]  STEP_TERM   = STEP_W'(16);
  localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(19);

  localparam logic [7:0] CLOCK_BIT = 8'h80;
  localparam logic [7:0] TERM_A    = 8'h0F;
  localparam logic [7:0] TERM_B    = 8'h8F;
  localparam logic [7:0] TERM_C    = 8'h00;

  typedef enum logic {
    OP_XCHG  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PORT = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XCHG,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       keep;
  } cmd_t;

  // terminate pattern after the eight data bits
  function automatic logic [7:0] term_word(input logic [1:0] sel);
    logic [7:0] w;
    case (sel)
      2'd0:    w = TERM_A;
      2'd1:    w = TERM_B;
      2'd2:    w = TERM_A;
      default: w = TERM_C;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/bsx_ram.sv
// generic single-port-write ram with registered read
module bsx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bsx_front.sv
// command intake: classifies items and queues them for the back end
module bsx_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [7:0]         tx_byte,
  input  logic [7:0]         rx_bits,
  input  logic               rx_valid,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               q_valid,
  output bsx_pkg::cmd_t      q_head,
  input  logic               q_pop
);

  logic                      allow_zeros;
  bsx_pkg::cmd_t             entries [bsx_pkg::QDEPTH];
  logic [bsx_pkg::QPTR_W-1:0] wr_ptr;
  logic [bsx_pkg::QPTR_W-1:0] rd_ptr;
  logic [bsx_pkg::QPTR_W:0]   fill;
  logic                      push;
  bsx_pkg::cmd_t             cmd;

  assign busy    = (fill == (bsx_pkg::QPTR_W + 1)'(bsx_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_head  = entries[rd_ptr];

  always_comb begin
    cmd.op      = bsx_pkg::op_t'(op);
    cmd.tx_byte = tx_byte;
    cmd.rx_byte = rx_bits;
    // receive byte goes to the store only if sampled valid and not a filtered zero
    cmd.keep    = (bsx_pkg::op_t'(op) == bsx_pkg::OP_XCHG) && rx_valid &&
                  ((rx_bits != 8'd0) || allow_zeros);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_zeros <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_zeros <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/bsx_back.sv
// execution engine: port word sequencer, receive store and drain walker
module bsx_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  bsx_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         strobe,
  output logic                         kind,
  output logic [7:0]                   port_word,
  output logic [7:0]                   data_byte,
  output logic [bsx_pkg::COUNT_W-1:0]  byte_count,
  output logic                         last
);

  bsx_pkg::state_t               state, state_next;
  logic [bsx_pkg::STEP_W-1:0]    step, step_next;
  logic [7:0]                    tx, tx_next;
  logic [bsx_pkg::COUNT_W-1:0]   count, count_next;
  logic [bsx_pkg::COUNT_W-1:0]   n, n_next;
  logic [bsx_pkg::COUNT_W-1:0]   idx, idx_next;
  logic                          pend, pend_next;
  logic                          pend_last, pend_last_next;

  logic                          strobe_next;
  bsx_pkg::kind_t                kind_r, kind_next;
  logic [7:0]                    port_word_next;
  logic [7:0]                    data_byte_next;
  logic [bsx_pkg::COUNT_W-1:0]   byte_count_next;
  logic                          last_next;

  logic                          ram_we;
  logic [7:0]                    ram_rdata;
  logic [7:0]                    xchg_word;

  bsx_ram #(
    .WIDTH (8),
    .DEPTH (bsx_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[bsx_pkg::ADDR_W-1:0]),
    .wdata (q_head.rx_byte),
    .raddr (idx[bsx_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // data bits msb first, clock low then high, then the terminate pattern
  always_comb begin
    if (step < bsx_pkg::STEP_TERM) begin
      xchg_word = {step[0], 6'd0, tx[~step[3:1]]};
    end else begin
      xchg_word = bsx_pkg::term_word(step[1:0]);
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    tx_next         = tx;
    count_next      = count;
    n_next          = n;
    idx_next        = idx;
    pend_next       = 1'b0;
    pend_last_next  = pend_last;
    strobe_next     = 1'b0;
    kind_next       = kind_r;
    port_word_next  = port_word;
    data_byte_next  = data_byte;
    byte_count_next = byte_count;
    last_next       = last;
    q_pop           = 1'b0;
    ram_we          = 1'b0;

    // read issued last cycle comes back now
    if (pend) begin
      strobe_next     = 1'b1;
      kind_next       = bsx_pkg::KIND_DATA;
      port_word_next  = 8'd0;
      data_byte_next  = ram_rdata;
      byte_count_next = n;
      last_next       = pend_last;
    end

    case (state)
      bsx_pkg::ST_IDLE: begin
        if (q_valid && !pend) begin
          q_pop = 1'b1;
          if (q_head.op == bsx_pkg::OP_XCHG) begin
            tx_next    = q_head.tx_byte;
            step_next  = '0;
            state_next = bsx_pkg::ST_XCHG;
            if (q_head.keep && (count < bsx_pkg::STORE_LIMIT)) begin
              ram_we     = 1'b1;
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            strobe_next     = 1'b1;
            kind_next       = bsx_pkg::KIND_DATA;
            port_word_next  = 8'd0;
            data_byte_next  = 8'd0;
            byte_count_next = '0;
            last_next       = 1'b1;
          end else begin
            n_next     = count;
            idx_next   = '0;
            count_next = '0;
            state_next = bsx_pkg::ST_DRAIN;
          end
        end
      end
      bsx_pkg::ST_XCHG: begin
        strobe_next     = 1'b1;
        kind_next       = bsx_pkg::KIND_PORT;
        port_word_next  = xchg_word;
        data_byte_next  = 8'd0;
        byte_count_next = '0;
        last_next       = (step == bsx_pkg::STEP_LAST);
        step_next       = step + 1'b1;
        if (step == bsx_pkg::STEP_LAST) begin
          state_next = bsx_pkg::ST_IDLE;
        end
      end
      bsx_pkg::ST_DRAIN: begin
        pend_next      = 1'b1;
        pend_last_next = ((idx + 1'b1) == n);
        idx_next       = idx + 1'b1;
        if ((idx + 1'b1) == n) begin
          state_next = bsx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bsx_pkg::ST_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    step       <= step_next;
    tx         <= tx_next;
    n          <= n_next;
    idx        <= idx_next;
    pend_last  <= pend_last_next;
    kind_r     <= kind_next;
    port_word  <= port_word_next;
    data_byte  <= data_byte_next;
    byte_count <= byte_count_next;
    last       <= last_next;
  end

  assign kind = kind_r;

endmodule

>>> rtl/core/bitbang_serial_exchange_with_rx_buffer.sv
// top level: serial exchanger with receive store, front intake and back engine
// exchange: command goes through queue, state and port word registers, 20 words
//   back to back, one beat per cycle
// drain of n stored bytes: state, RAM read, pend registered; n beats back to back
//   (store read port gives one byte a cycle); empty drain gives one beat
// busy rises when the two-entry command queue is full; results cannot be stalled
// synchronous reset clears the queue, the byte count and the config register
module bitbang_serial_exchange_with_rx_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op,
  input  logic [7:0]                   tx_byte,
  input  logic [7:0]                   rx_bits,
  input  logic                         rx_valid,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  output logic                         strobe,
  output logic                         kind,
  output logic [7:0]                   port_word,
  output logic [7:0]                   data_byte,
  output logic [bsx_pkg::COUNT_W-1:0]  byte_count,
  output logic                         last
);

  logic          q_valid;
  logic          q_pop;
  bsx_pkg::cmd_t q_head;

  bsx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .tx_byte     (tx_byte),
    .rx_bits     (rx_bits),
    .rx_valid    (rx_valid),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  bsx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .strobe     (strobe),
    .kind       (kind),
    .port_word  (port_word),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .last       (last)
  );

  // an exchange run has no gaps
  a_port_run: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == bsx_pkg::KIND_PORT) && !last
      |=> strobe && (kind == bsx_pkg::KIND_PORT))
    else $error("gap in exchange run");

  // a drain run has no gaps
  a_drain_run: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == bsx_pkg::KIND_DATA) && !last
      |=> strobe && (kind == bsx_pkg::KIND_DATA))
    else $error("gap in drain run");

  // an empty drain is a single zero beat
  a_empty_drain: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == bsx_pkg::KIND_DATA) && (byte_count == '0)
      |-> last && (data_byte == 8'd0))
    else $error("bad empty drain beat");

endmodule

>>> tb/sv/bsx_checker.sv
// checker for the serial exchanger: predicts port and drain beats and compares them
`timescale 1ns / 1ps

module bsx_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        op,
  input  logic [7:0]                  tx_byte,
  input  logic [7:0]                  rx_bits,
  input  logic                        rx_valid,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        strobe,
  input  logic                        kind,
  input  logic [7:0]                  port_word,
  input  logic [7:0]                  data_byte,
  input  logic [bsx_pkg::COUNT_W-1:0] byte_count,
  input  logic                        last,
  output int                          errors,
  output int                          pending,
  output int                          n_xchg,
  output int                          n_drain,
  output int                          n_beats,
  output int                          peak_held,
  output int                          n_dropped_full
);

  typedef struct packed {
    bsx_pkg::kind_t              kind;
    logic [7:0]                  port_word;
    logic [7:0]                  data_byte;
    logic [bsx_pkg::COUNT_W-1:0] byte_count;
    logic                        last;
  } beat_t;

  beat_t       due_beats[$];
  logic [7:0]  held_bytes[bsx_pkg::STORE_DEPTH];
  int unsigned held_count;
  logic        zeros_ok;

  initial begin
    errors = 0;
    pending = 0;
    n_xchg = 0;
    n_drain = 0;
    n_beats = 0;
    peak_held = 0;
    n_dropped_full = 0;
    held_count = 0;
    zeros_ok = 1'b0;
  end

  task automatic push_beat(input bsx_pkg::kind_t k, input logic [7:0] pw,
                           input logic [7:0] db,
                           input logic [bsx_pkg::COUNT_W-1:0] cnt, input logic lst);
    beat_t b;
    b.kind = k;
    b.port_word = pw;
    b.data_byte = db;
    b.byte_count = cnt;
    b.last = lst;
    due_beats.push_back(b);
  endtask

  task automatic predict_command(input bsx_pkg::op_t cmd_op, input logic [7:0] tx,
                                 input logic [7:0] rx, input logic vld);
    logic [7:0] bit_word;
    if (cmd_op == bsx_pkg::OP_XCHG) begin
      n_xchg++;
      for (int j = 7; j >= 0; j--) begin
        bit_word = {7'b0, tx[3'(j)]};
        push_beat(bsx_pkg::KIND_PORT, bit_word, 8'h00, '0, 1'b0);
        push_beat(bsx_pkg::KIND_PORT, bit_word | bsx_pkg::CLOCK_BIT, 8'h00, '0, 1'b0);
      end
      push_beat(bsx_pkg::KIND_PORT, bsx_pkg::TERM_A, 8'h00, '0, 1'b0);
      push_beat(bsx_pkg::KIND_PORT, bsx_pkg::TERM_B, 8'h00, '0, 1'b0);
      push_beat(bsx_pkg::KIND_PORT, bsx_pkg::TERM_A, 8'h00, '0, 1'b0);
      push_beat(bsx_pkg::KIND_PORT, bsx_pkg::TERM_C, 8'h00, '0, 1'b1);
      if (vld && (rx != 8'h00 || zeros_ok)) begin
        // one slot is always kept free
        if (held_count < bsx_pkg::STORE_DEPTH - 1) begin
          held_bytes[(bsx_pkg::ADDR_W)'(held_count)] = rx;
          held_count++;
          if (held_count > peak_held) peak_held = held_count;
        end else begin
          n_dropped_full++;
        end
      end
    end else begin
      n_drain++;
      if (held_count == 0) begin
        push_beat(bsx_pkg::KIND_DATA, 8'h00, 8'h00, '0, 1'b1);
      end else begin
        for (int i = 0; i < held_count; i++)
          push_beat(bsx_pkg::KIND_DATA, 8'h00, held_bytes[(bsx_pkg::ADDR_W)'(i)],
                    (bsx_pkg::COUNT_W)'(held_count), (i + 1 == held_count));
        held_count = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("mismatch at beat %0d: %s got %0h want %0h", n_beats, what, got, want);
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      due_beats.delete();
      held_count = 0;
      zeros_ok = 1'b0;
    end else begin
      if (strobe) begin
        if (due_beats.size() == 0) begin
          report_mismatch("beat with nothing due, port_word", port_word, 8'h00);
        end else begin
          want = due_beats.pop_front();
          if (kind !== want.kind)
            report_mismatch("kind", {7'b0, kind}, {7'b0, want.kind});
          if (port_word !== want.port_word)
            report_mismatch("port_word", port_word, want.port_word);
          if (data_byte !== want.data_byte)
            report_mismatch("data_byte", data_byte, want.data_byte);
          if (byte_count !== want.byte_count)
            report_mismatch("byte_count", 8'(byte_count), 8'(want.byte_count));
          if (last !== want.last)
            report_mismatch("last", {7'b0, last}, {7'b0, want.last});
        end
        n_beats++;
      end
      if (start && !busy)
        predict_command(bsx_pkg::op_t'(op), tx_byte, rx_bits, rx_valid);
      if (cfg_wr_en)
        zeros_ok = cfg_wr_data;
    end
    pending = due_beats.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the serial exchanger: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  bsx_pkg::op_t                op;
  logic [7:0]                  tx_byte;
  logic [7:0]                  rx_bits;
  logic                        rx_valid;
  logic                        cfg_wr_en;
  logic                        cfg_wr_data;
  logic                        strobe;
  logic                        kind;
  logic [7:0]                  port_word;
  logic [7:0]                  data_byte;
  logic [bsx_pkg::COUNT_W-1:0] byte_count;
  logic                        last;

  int errors, pending, n_xchg, n_drain, n_beats, peak_held, n_dropped_full;
  int idle_cycles;
  int burst_left;

  bitbang_serial_exchange_with_rx_buffer u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .tx_byte    (tx_byte),
    .rx_bits    (rx_bits),
    .rx_valid   (rx_valid),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .strobe     (strobe),
    .kind       (kind),
    .port_word  (port_word),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .last       (last)
  );

  bsx_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .tx_byte       (tx_byte),
    .rx_bits       (rx_bits),
    .rx_valid      (rx_valid),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .strobe        (strobe),
    .kind          (kind),
    .port_word     (port_word),
    .data_byte     (data_byte),
    .byte_count    (byte_count),
    .last          (last),
    .errors        (errors),
    .pending       (pending),
    .n_xchg        (n_xchg),
    .n_drain       (n_drain),
    .n_beats       (n_beats),
    .peak_held     (peak_held),
    .n_dropped_full(n_dropped_full)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // no beat moving in either direction for too long means the block hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d beats outstanding", pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input bsx_pkg::op_t cmd_op, input logic [7:0] tx,
                          input logic [7:0] rx, input logic vld);
    start <= 1'b1;
    op <= cmd_op;
    tx_byte <= tx;
    rx_bits <= rx;
    rx_valid <= vld;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // bursts of random length, random gaps with junk on the fields
  task automatic pace(input bit no_gaps);
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        op <= bsx_pkg::op_t'($urandom_range(0, 1));
        tx_byte <= 8'($urandom);
        rx_bits <= 8'($urandom);
        rx_valid <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_allow_zeros(input logic val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int drain_pct, input int zero_pct,
                           input int valid_pct, input bit no_gaps);
    bsx_pkg::op_t cmd_op;
    logic [7:0]   rx;
    for (int i = 0; i < n; i++) begin
      cmd_op = ($urandom_range(0, 99) < drain_pct) ? bsx_pkg::OP_DRAIN : bsx_pkg::OP_XCHG;
      rx = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom);
      send_cmd(cmd_op, 8'($urandom), rx, $urandom_range(0, 99) < valid_pct);
      pace(no_gaps);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    op <= bsx_pkg::OP_XCHG;
    tx_byte <= 8'h00;
    rx_bits <= 8'h00;
    rx_valid <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    idle_cycles <= 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty drain, zero discard, invalid sample, bit extremes
    send_cmd(bsx_pkg::OP_DRAIN, 8'h00, 8'h00, 1'b0);
    send_cmd(bsx_pkg::OP_XCHG, 8'h00, 8'h00, 1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'hFF, 8'hFF, 1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'hA5, 8'h5A, 1'b0);
    send_cmd(bsx_pkg::OP_XCHG, 8'h5A, 8'h01, 1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'h80, 8'h80, 1'b1);
    send_cmd(bsx_pkg::OP_DRAIN, 8'hFF, 8'hFF, 1'b1);
    send_cmd(bsx_pkg::OP_DRAIN, 8'h00, 8'h00, 1'b0);
    write_allow_zeros(1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'h01, 8'h00, 1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'h7F, 8'hFE, 1'b1);
    send_cmd(bsx_pkg::OP_XCHG, 8'h00, 8'h00, 1'b0);
    send_cmd(bsx_pkg::OP_XCHG, 8'hC3, 8'h00, 1'b1);
    send_cmd(bsx_pkg::OP_DRAIN, 8'h00, 8'h00, 1'b0);
    send_cmd(bsx_pkg::OP_DRAIN, 8'h00, 8'h00, 1'b0);

    // mixed traffic with zeros kept
    run_phase(25, 20, 15, 85, 1'b0);

    // fill the store past its limit with zeros discarded, then drain it all
    write_allow_zeros(1'b0);
    run_phase(75, 0, 2, 98, 1'b0);
    send_cmd(bsx_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    send_cmd(bsx_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));

    // back to back traffic, no gaps
    write_allow_zeros(1'b1);
    run_phase(20, 25, 20, 85, 1'b1);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d exchanges and %0d drains, %0d result beats compared",
             n_xchg, n_drain, n_beats);
    $display("store peaked at %0d bytes, %0d bytes dropped on a full store",
             peak_held, n_dropped_full);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d beats never seen", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
